@@ hw/rtl/dmf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmf_pkg
// Shared types and constants for the duplicate message filter.
// ----------------------------------------------------------------------------
package dmf_pkg;

	localparam int unsigned DEPTH_DEFAULT = 64;
	localparam logic [31:0] LIFETIME_RESET = 32'd15000;
	localparam int unsigned HASH_MULT = 31;

	// src*31+seq fits in 13 bits
	localparam int unsigned HASH_BITS = 13;
	// home slot: reciprocal multiply, then back-multiply and subtract
	localparam int unsigned HASH_STEPS = 2;
	localparam int unsigned HCNT_W = 1;
	localparam logic [HCNT_W-1:0] HCNT_LAST = HCNT_W'(HASH_STEPS - 1);

	localparam int unsigned SLOT_W = 6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HASH,
		ST_INIT,
		ST_READ,
		ST_EVAL,
		ST_COMMIT
	} dmf_state_t;

	typedef struct packed {
		logic load;
		logic hash_step;
		logic probe_init;
		logic eval;
		logic commit;
	} dmf_cmd_t;

	typedef struct packed {
		logic hash_done;
		logic probe_last;
		logic out_busy;
	} dmf_status_t;

	typedef struct packed {
		logic [7:0]  src;
		logic [7:0]  seq;
		logic [31:0] stamp;
	} dmf_entry_t;

endpackage

@@ hw/rtl/dmf_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmf_ctrl
// Sequencer: hash, probe pass over all slots, then commit of the result.
// ----------------------------------------------------------------------------
module dmf_ctrl
	import dmf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  dmf_status_t status,
	output dmf_cmd_t    cmd
);

	dmf_state_t state_q;
	dmf_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_HASH;
			end
			ST_HASH: begin
				if (status.hash_done) state_d = ST_INIT;
			end
			ST_INIT: state_d = ST_READ;
			ST_READ: state_d = ST_EVAL;
			ST_EVAL: begin
				state_d = status.probe_last ? ST_COMMIT : ST_READ;
			end
			ST_COMMIT: begin
				if (!status.out_busy) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_HASH:   cmd.hash_step = 1'b1;
			ST_INIT:   cmd.probe_init = 1'b1;
			ST_READ:   ;
			ST_EVAL:   cmd.eval = 1'b1;
			ST_COMMIT: cmd.commit = !status.out_busy;
			default:   ;
		endcase
	end

endmodule

@@ hw/rtl/dmf_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmf_datapath
// Entry memory, valid bits, hash remainder unit, probe logic and result word.
// ----------------------------------------------------------------------------
module dmf_datapath
	import dmf_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = DEPTH_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dmf_cmd_t          cmd,
	output dmf_status_t       status,
	input  logic [7:0]        src_id,
	input  logic [7:0]        msg_seq,
	input  logic [31:0]       now_ms,
	input  logic              cfg_we,
	input  logic [31:0]       cfg_data,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              is_duplicate,
	output logic              table_flushed,
	output logic [SLOT_W-1:0] slot_index
);

	localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
	localparam int unsigned EXT_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
	localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_DEPTH - 1);
	localparam logic [IDX_W:0] DEPTH_X = (IDX_W + 1)'(TABLE_DEPTH);
	localparam logic [TABLE_DEPTH-1:0] ONE_AT_0 = TABLE_DEPTH'(1);

	// floor(x*M >> SH) == floor(x/TABLE_DEPTH) for every 13-bit x
	localparam int unsigned RECIP_SH = HASH_BITS + IDX_W;
	localparam int unsigned RECIP_W = HASH_BITS + 1;
	localparam logic [RECIP_W-1:0] RECIP_M =
		RECIP_W'(((1 << RECIP_SH) + TABLE_DEPTH - 1) / TABLE_DEPTH);
	localparam int unsigned PROD_W = HASH_BITS + RECIP_W;
	localparam int unsigned QUOT_W = PROD_W - RECIP_SH;
	localparam logic [HASH_BITS-1:0] DEPTH_H = HASH_BITS'(TABLE_DEPTH);

	dmf_entry_t mem [TABLE_DEPTH];
	dmf_entry_t rd_q;

	logic [7:0]             src_q;
	logic [7:0]             seq_q;
	logic [31:0]            now_q;
	logic [31:0]            lifetime_q;
	logic [HASH_BITS-1:0]   sum_q;
	logic [HCNT_W-1:0]      hcnt_q;
	logic [QUOT_W-1:0]      quot_q;
	logic [IDX_W-1:0]       home_q;
	logic [IDX_W-1:0]       probe_q;
	logic [IDX_W-1:0]       cnt_q;
	logic                   dup_q;
	logic                   have_free_q;
	logic [IDX_W-1:0]       match_q;
	logic [IDX_W-1:0]       free_q;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic                   out_valid_q;
	logic                   dup_out_q;
	logic                   flush_out_q;
	logic [IDX_W-1:0]       slot_out_q;

	logic [PROD_W-1:0]      prod;
	logic [HASH_BITS-1:0]   back;
	logic [HASH_BITS-1:0]   rem;
	logic [31:0]        age;
	logic               slot_valid;
	logic               expired;
	logic               live;
	logic               matched;
	logic               flush;
	logic [IDX_W-1:0]   commit_slot;
	logic [EXT_W-1:0]   slot_ext;

	assign prod        = PROD_W'(sum_q) * PROD_W'(RECIP_M);
	assign back        = HASH_BITS'(quot_q) * DEPTH_H;
	assign rem         = sum_q - back;
	assign age         = now_q - rd_q.stamp;
	assign slot_valid  = valid_q[probe_q];
	assign expired     = age > lifetime_q;
	assign live        = slot_valid && !expired;
	assign matched     = (rd_q.src == src_q) && (rd_q.seq == seq_q);
	assign flush       = !dup_q && !have_free_q;
	assign commit_slot = dup_q ? match_q : (have_free_q ? free_q : home_q);

	assign status.hash_done  = (hcnt_q == HCNT_LAST);
	assign status.probe_last = (cnt_q == LAST);
	assign status.out_busy   = out_valid_q && out_stall;

	// entry memory, registered read at the probe slot
	always_ff @(posedge clk) begin
		if (cmd.commit && !dup_q) begin
			mem[commit_slot] <= '{src: src_q, seq: seq_q, stamp: now_q};
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[probe_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lifetime_q <= LIFETIME_RESET;
		end else if (cfg_we) begin
			lifetime_q <= cfg_data;
		end
	end

	// item capture, hash remainder (quotient first, then remainder) and probe bookkeeping
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			src_q  <= src_id;
			seq_q  <= msg_seq;
			now_q  <= now_ms;
			sum_q  <= HASH_BITS'(src_id) * HASH_BITS'(HASH_MULT) + HASH_BITS'(msg_seq);
			hcnt_q <= '0;
			home_q <= '0;
		end
		if (cmd.hash_step) begin
			hcnt_q <= hcnt_q + 1'b1;
			quot_q <= prod[PROD_W-1:RECIP_SH];
			home_q <= rem[IDX_W-1:0];
		end
		if (cmd.probe_init) begin
			probe_q     <= home_q;
			cnt_q       <= '0;
			dup_q       <= 1'b0;
			have_free_q <= 1'b0;
		end
		if (cmd.eval) begin
			probe_q <= (probe_q == LAST) ? '0 : probe_q + 1'b1;
			cnt_q   <= cnt_q + 1'b1;
			if (!live && !have_free_q) begin
				have_free_q <= 1'b1;
				free_q      <= probe_q;
			end
			if (live && !dup_q && matched) begin
				dup_q   <= 1'b1;
				match_q <= probe_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.commit && flush) begin
			valid_q <= ONE_AT_0 << home_q;
		end else if (cmd.commit && !dup_q) begin
			valid_q[free_q] <= 1'b1;
		end else if (cmd.eval && slot_valid && expired) begin
			valid_q[probe_q] <= 1'b0;
		end
	end

	// result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			dup_out_q   <= dup_q;
			flush_out_q <= flush;
			slot_out_q  <= commit_slot;
		end
	end

	assign slot_ext      = EXT_W'(slot_out_q);
	assign out_valid     = out_valid_q;
	assign is_duplicate  = dup_out_q;
	assign table_flushed = flush_out_q;
	assign slot_index    = slot_ext[SLOT_W-1:0];

	a_no_commit_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !(out_valid_q && out_stall))
		else $error("result committed over a word still waiting");

	a_dup_not_flushed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(dup_out_q && flush_out_q))
		else $error("duplicate reported together with flush");

	a_flush_one_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && flush) |=> ($countones(valid_q) == 1))
		else $error("flush left other than one valid slot");

	a_store_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && !dup_q) |=> valid_q[$past(commit_slot)])
		else $error("stored slot not marked valid");

	a_hash_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.probe_init |-> ((IDX_W + 1)'(home_q) < DEPTH_X))
		else $error("home slot beyond table depth");

endmodule

@@ hw/rtl/duplicate_message_filter_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// duplicate_message_filter_core
// Duplicate suppression cache of (source, sequence) pairs with linear probing
// and expiry by age.
// ----------------------------------------------------------------------------
//
//  channel  | handshake           | payload
//  ---------+---------------------+--------------------------------------
//  input    | in_valid / in_stall | src_id, msg_seq, now_ms
//  result   | out_valid/out_stall | is_duplicate, table_flushed, slot_index
//  config   | cfg_valid/cfg_ready | cfg_data (entry lifetime, ms)
//
//  one word passes from accept to result through the home slot calculation
//  (reciprocal multiply, then back-multiply and subtract), a probe start, an
//  entry memory read and an age/match check for each slot, then a commit
//  in_stall is low only while idle, so a new word is taken only after the
//  last one has committed; a finished result waits in the output register
//  and the next word may be taken meanwhile, commit waits while that
//  register is stalled
//  reset clears the valid bits and sets the lifetime to 15000 at once; no sweep
//  cfg_ready is always high
//
module duplicate_message_filter_core
	import dmf_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = DEPTH_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        src_id,
	input  logic [7:0]        msg_seq,
	input  logic [31:0]       now_ms,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              is_duplicate,
	output logic              table_flushed,
	output logic [SLOT_W-1:0] slot_index,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [31:0]       cfg_data
);

	dmf_cmd_t    cmd;
	dmf_status_t status;

	assign cfg_ready = 1'b1;

	dmf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	dmf_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.src_id        (src_id),
		.msg_seq       (msg_seq),
		.now_ms        (now_ms),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_data      (cfg_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.is_duplicate  (is_duplicate),
		.table_flushed (table_flushed),
		.slot_index    (slot_index)
	);

endmodule
